### hw/rtl/ip_range_binary_lookup_core_assert.svh
// Assertion macros used by the address-range lookup RTL.
`ifndef IP_RANGE_BINARY_LOOKUP_CORE_ASSERT_SVH
`define IP_RANGE_BINARY_LOOKUP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define IPRBL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define IPRBL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define IPRBL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define IPRBL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### hw/rtl/iprbl_pkg.sv
// Shared types and constants of the address-range lookup block.
package iprbl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int ADDR_W      = 32;
  localparam int REC_W       = 24;

  // Highest usable table index
  localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(TABLE_DEPTH - 1);

  // Input word kind carried on tuser
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [REC_W-1:0]  record_ref;
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] range_begin;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/iprbl_ram.sv
// Generic single-port RAM with registered read data.
module iprbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ip_range_binary_lookup_core.sv
// Address-range lookup: sorted range table in RAM searched by a binary-search sequencer.
//
// A write word (tuser = 0) stores one table entry, and the input side stays ready. A
// lookup word (tuser = 1) runs a binary search over entries 0 to last_entry_index. Each
// probe presents the RAM address, then compares the registered read word against begin
// and end. When the address lies below entry zero or the bounds cross, the last entry is
// read back and returned with found cleared. A 4096-entry table needs up to 13 probes;
// the result then waits until the output register is free. The table RAM is single-port
// with a registered read. The input side is not ready while a lookup runs. The result
// sits in an output register, so a new word is taken while an earlier result still waits.
// The user must write last_entry_index through the cfg port only while the block is idle;
// the block itself does not enforce this.
`include "ip_range_binary_lookup_core_assert.svh"

module ip_range_binary_lookup_core
  import iprbl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: last_entry_index
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [11:0]  cfg_data,
  // Input words
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // entry_index, range_begin, range_end, record_ref, query_ip
  input  logic [0:0]   in_tuser,   // func
  // Result words
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // match_index, match_begin, match_end, match_record
  output logic [0:0]   out_tuser   // found
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FB_READ,
    ST_FB_CMP,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [ADDR_W-1:0] query_r, query_nxt;
  logic [IDX_W:0]    lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic              res_found_r, res_found_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  entry_t            out_entry_r, out_entry_nxt;

  logic              in_fire;
  func_t             in_func;
  logic [IDX_W-1:0]  in_entry_index;
  entry_t            in_entry;
  logic [ADDR_W-1:0] in_query;
  logic [IDX_W-1:0]  last_lim;
  logic [IDX_W+1:0]  bound_sum;
  logic [IDX_W-1:0]  mid_w;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_rdata;

  // Unpack the input word
  assign in_func                 = func_t'(in_tuser[0]);
  assign in_entry_index          = in_tdata[11:0];
  assign in_entry.range_begin    = in_tdata[43:12];
  assign in_entry.range_end      = in_tdata[75:44];
  assign in_entry.record_ref     = in_tdata[99:76];
  assign in_query                = in_tdata[131:100];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Clamp the last index to the table
  assign last_lim  = (last_r > LAST_MAX) ? LAST_MAX : last_r;

  // Midpoint of the current bounds
  assign bound_sum = {1'b0, lo_r} + {2'b00, hi_r};
  assign mid_w     = bound_sum[IDX_W:1];

  // Table RAM port: write on an accepted write word, else read the probe or last-entry address
  assign ram_we = in_fire && (in_func == FUNC_WRITE) && (in_entry_index <= LAST_MAX);

  always_comb begin
    case (state_r)
      ST_IDLE:    ram_addr = in_entry_index;
      ST_PROBE:   ram_addr = mid_w;
      ST_FB_READ: ram_addr = last_lim;
      default:    ram_addr = mid_r;
    endcase
  end

  iprbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_entry),
    .rdata (ram_rdata)
  );

  // Search sequencer
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    query_nxt     = query_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_entry_nxt = res_entry_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_entry_nxt = out_entry_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      last_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_func == FUNC_LOOKUP)) begin
          query_nxt = in_query;
          lo_nxt    = '0;
          hi_nxt    = last_lim;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_r > {1'b0, hi_r}) begin
          state_nxt = ST_FB_READ;
        end else begin
          mid_nxt   = mid_w;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (query_r < ram_rdata.range_begin) begin
          // Below entry zero ends the search
          if (mid_r == '0) begin
            state_nxt = ST_FB_READ;
          end else begin
            hi_nxt    = mid_r - 1'b1;
            state_nxt = ST_PROBE;
          end
        end else if (query_r > ram_rdata.range_end) begin
          lo_nxt    = {1'b0, mid_r} + 1'b1;
          state_nxt = ST_PROBE;
        end else begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = mid_r;
          res_entry_nxt = ram_rdata;
          state_nxt     = ST_DONE;
        end
      end
      ST_FB_READ: begin
        state_nxt = ST_FB_CMP;
      end
      ST_FB_CMP: begin
        res_found_nxt = 1'b0;
        res_idx_nxt   = last_lim;
        res_entry_nxt = ram_rdata;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          out_entry_nxt = res_entry_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    query_r     <= query_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_entry_r <= res_entry_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_entry_r <= out_entry_nxt;
  end

  // Pack the result word
  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_found_r;
  assign out_tdata    = {4'b0000, out_entry_r.record_ref, out_entry_r.range_end,
                         out_entry_r.range_begin, out_idx_r};

  // Probe index stays within the live bounds
  `IPRBL_ASSERT_IMP(a_mid_in_bounds, clk, rst_n, state_r == ST_CMP, (mid_r <= hi_r) && ({1'b0, mid_r} >= lo_r))
  // Upper bound never passes the clamped last index
  `IPRBL_ASSERT_IMP(a_hi_in_table, clk, rst_n, state_r != ST_IDLE, hi_r <= last_lim)
  // Lower bound never runs more than one past the upper bound
  `IPRBL_ASSERT_IMP(a_lo_limit, clk, rst_n, state_r == ST_PROBE, lo_r <= ({1'b0, hi_r} + 1'b1))
  // A lookup word starts a probe and closes the input side
  `IPRBL_ASSERT_NXT(a_lookup_start, clk, rst_n, in_fire && (in_func == FUNC_LOOKUP), (state_r == ST_PROBE) && !in_tready)

endmodule
